/* hw/rtl/wpfg_pkg.sv */
package wpfg_pkg;

    typedef struct packed {
        logic signed [31:0] hyp_x;
        logic signed [31:0] hyp_y;
        logic signed [15:0] hyp_yaw;
        logic        [23:0] hyp_rms;
        logic               last_in_frame;
    } t_hyp;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] pose_yaw;
        logic        [1:0]  pose_origin;
    } t_pose;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_WWAIT, S_SC_START, S_SC_WAIT,
        S_M0, S_M1, S_M2, S_M3, S_M4,
        S_FEND, S_DX_WAIT, S_DY_START, S_DY_WAIT,
        S_AT_PREP, S_AT_NORM, S_AT_WAIT,
        S_G0, S_G1, S_G2, S_G3, S_G4, S_OUT
    } t_state;

    typedef enum logic {
        CM_ROT,
        CM_VEC
    } t_cmode;

    typedef struct packed {
        logic   start;
        t_cmode mode;
    } t_cordic_req;

    localparam int DVD_W = 62;
    localparam int DVS_W = 30;
    localparam int QUO_W = 33;
    localparam int CRD_W = 48;

    localparam logic [1:0] REG_RMS_LIMIT = 2'd0;
    localparam logic [1:0] REG_WEIGHT_EPS = 2'd1;
    localparam logic [1:0] REG_GATE_DIST = 2'd2;

    localparam logic [1:0] SRC_FIRST = 2'd0;
    localparam logic [1:0] SRC_ACCEPT = 2'd1;
    localparam logic [1:0] SRC_REJECT = 2'd2;

    localparam logic [23:0] WEIGHT_MAX = 24'hFF_FFFF;
    localparam logic [24:0] SAT_DEN = 25'd65536;
    localparam logic [5:0] W_STEPS = 6'd24;
    localparam logic [5:0] M_STEPS = 6'd33;
    localparam logic signed [CRD_W-1:0] GAIN_Q30 = 48'sd652032874;
    localparam logic signed [CRD_W-1:0] NORM_LIM = 48'sh1000_0000_0000;

    function automatic logic [31:0] atan_ent(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0: v = 32'h2000_0000;
            5'd1: v = 32'h12E4_051E;
            5'd2: v = 32'h09FB_385B;
            5'd3: v = 32'h0511_11D4;
            5'd4: v = 32'h028B_0D43;
            5'd5: v = 32'h0145_D7E1;
            5'd6: v = 32'h00A2_F61E;
            5'd7: v = 32'h0051_7C55;
            5'd8: v = 32'h0028_BE53;
            5'd9: v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2FA;
            5'd15: v = 32'h0000_517D;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A30;
            5'd19: v = 32'h0000_0518;
            5'd20: v = 32'h0000_028C;
            5'd21: v = 32'h0000_0146;
            5'd22: v = 32'h0000_00A3;
            5'd23: v = 32'h0000_0051;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/wpfg_div.sv */
module wpfg_div
    import wpfg_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    input  logic [5:0]       i_steps,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quot
);

    logic [DVS_W:0]   r_rem;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [QUO_W-1:0] r_q;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W+1:0] trial;
    logic             ge;

    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        ge = (trial >= {2'b00, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= (DVS_W+1)'(i_dividend >> i_steps);
            r_dvd <= i_dividend << (7'd62 - {1'b0, i_steps});
            r_dvs <= i_divisor;
            r_q <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? (DVS_W+1)'(trial - {2'b00, r_dvs}) : trial[DVS_W:0];
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_q <= {r_q[QUO_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* hw/rtl/wpfg_cordic.sv */
module wpfg_cordic
    import wpfg_pkg::*;
#(
    parameter int STEPS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cordic_req             i_req,
    input  logic signed [CRD_W-1:0] i_x,
    input  logic signed [CRD_W-1:0] i_y,
    input  logic [31:0]             i_z,
    output logic                    o_done,
    output logic signed [CRD_W-1:0] o_x,
    output logic signed [CRD_W-1:0] o_y,
    output logic [31:0]             o_z
);

    logic signed [CRD_W-1:0] r_x;
    logic signed [CRD_W-1:0] r_y;
    logic [31:0]             r_z;
    logic [4:0]              r_i;
    t_cmode                  r_mode;
    logic                    r_busy;
    logic                    r_done;
    logic signed [CRD_W-1:0] xs;
    logic signed [CRD_W-1:0] ys;
    logic                    neg;

    always_comb begin
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        neg = (r_mode == CM_VEC) ? (r_y > 0) : r_z[31];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_i <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 5'd1;
                if (r_i == 5'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
            r_mode <= i_req.mode;
        end else if (r_busy) begin
            if (neg) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_ent(r_i);
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_ent(r_i);
            end
        end
    end

    assign o_done = r_done;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

/* hw/rtl/weighted_pose_fusion_gate.sv */
// Fuses the pose hypotheses of one camera frame into one pose, with a jump gate.
// Input channel: i_hyp_valid / o_hyp_ready carry one hypothesis request per
// handshake; last_in_frame closes the frame. Output channel: o_pose_valid /
// i_pose_ready carry at most one pose per frame, only on the closing request.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx at once.
// One request is worked on at a time; o_hyp_ready is high only while idle.
// A kept hypothesis passes a 24-step restoring divider for the weight, a
// CORDIC_STEPS-step rotation CORDIC for cosine and sine, and the states M0 to
// M4 on the shared multiplier for the weighted sums; when the weight saturates
// the divider is skipped. Closing a frame adds two 33-step divisions for the
// mean position, up to 44 normalising shifts and a CORDIC_STEPS-step vectoring
// CORDIC for the yaw, and the gate states G0 to G4 (G0 alone for the first
// pose). A frame that keeps nothing closes in FEND with no pose.
// The pose sits in an output register: while the receiver stalls, the block
// keeps accepting hypotheses and only waits when a second pose is ready.
// Reset clears the sums, the stored pose and the registers to their defaults.
module weighted_pose_fusion_gate
    import wpfg_pkg::*;
#(
    parameter int MAX_HYPOTHESES = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_hyp_valid,
    output logic        o_hyp_ready,
    input  t_hyp        i_hyp,
    output logic        o_pose_valid,
    input  logic        i_pose_ready,
    output t_pose       o_pose,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [24:0] i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_HYPOTHESES + 1);

    t_state r_state, n_state;

    logic [23:0] r_rms_limit;
    logic [16:0] r_eps;
    logic [24:0] r_gate;

    t_hyp        r_hyp;
    logic [23:0] r_w;
    logic        r_flip;
    logic signed [17:0] r_c;
    logic signed [17:0] r_s;

    logic signed [59:0] r_sx;
    logic signed [59:0] r_sy;
    logic signed [43:0] r_sc;
    logic signed [43:0] r_ss;
    logic [28:0]        r_sw;
    logic [CNT_W-1:0]   r_count;

    logic signed [31:0] r_est_x;
    logic signed [31:0] r_est_y;
    logic signed [15:0] r_est_yaw;
    logic               r_have_est;

    logic signed [31:0] r_mx;
    logic signed [31:0] r_my;
    logic signed [15:0] r_myaw;
    logic               r_neg;
    logic signed [CRD_W-1:0] r_ax;
    logic signed [CRD_W-1:0] r_ay;
    logic [31:0]        r_az;
    logic [32:0]        r_adx;
    logic [32:0]        r_ady;
    logic               r_prerej;
    logic [50:0]        r_sq;
    logic [1:0]         r_src;
    logic signed [58:0] r_prod;

    t_pose r_out;
    logic  r_out_valid;

    logic [24:0] den;
    logic        keep;
    logic [31:0] sc_z0;
    logic [31:0] sc_zq;
    logic        sc_flip;

    logic               div_start;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic [5:0]         div_steps;
    logic               div_done;
    logic [QUO_W-1:0]   div_q;
    logic signed [59:0] mean_num;
    logic signed [61:0] mean_n;
    logic [QUO_W-1:0]   mean_q;

    t_cordic_req             crd_req;
    logic signed [CRD_W-1:0] crd_x0;
    logic signed [CRD_W-1:0] crd_y0;
    logic [31:0]             crd_z0;
    logic                    crd_done;
    logic signed [CRD_W-1:0] crd_x;
    logic signed [CRD_W-1:0] crd_y;
    logic [31:0]             crd_z;
    logic signed [CRD_W-1:0] c_raw;
    logic signed [CRD_W-1:0] s_raw;

    logic signed [25:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [58:0] mul_p;

    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic               norm_small;
    logic               out_load;

    always_comb begin
        den = {1'b0, r_hyp.hyp_rms} + {8'b0, r_eps};
        keep = (r_hyp.hyp_rms <= r_rms_limit) && (r_count < CNT_W'(MAX_HYPOTHESES));
        sc_z0 = {r_hyp.hyp_yaw, 16'h0000};
        sc_zq = sc_z0 + 32'h4000_0000;
        sc_flip = sc_zq[31];
        mean_num = (r_state == S_FEND) ? r_sx : r_sy;
        mean_n = ($signed({{2{mean_num[59]}}, mean_num}) <<< 1) + $signed({33'b0, r_sw});
        mean_q = r_neg ? ~div_q : div_q;
        c_raw = (crd_x + 48'sd32768) >>> 16;
        s_raw = (crd_y + 48'sd32768) >>> 16;
        dx = {r_mx[31], r_mx} - {r_est_x[31], r_est_x};
        dy = {r_my[31], r_my} - {r_est_y[31], r_est_y};
        norm_small = (r_ax < NORM_LIM) && (r_ax > -NORM_LIM)
            && (r_ay < NORM_LIM) && (r_ay > -NORM_LIM);
        mul_p = mul_a * mul_b;
    end

    always_comb begin
        mul_a = $signed({2'b00, r_w});
        mul_b = $signed({r_hyp.hyp_x[31], r_hyp.hyp_x});
        case (r_state)
            S_M1: mul_b = $signed({r_hyp.hyp_y[31], r_hyp.hyp_y});
            S_M2: mul_b = 33'(r_c);
            S_M3: mul_b = 33'(r_s);
            S_G1: begin
                mul_a = $signed({1'b0, r_adx[24:0]});
                mul_b = $signed({8'b0, r_adx[24:0]});
            end
            S_G2: begin
                mul_a = $signed({1'b0, r_ady[24:0]});
                mul_b = $signed({8'b0, r_ady[24:0]});
            end
            S_G3: begin
                mul_a = $signed({1'b0, r_gate});
                mul_b = $signed({8'b0, r_gate});
            end
            default: begin
                mul_a = $signed({2'b00, r_w});
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_hyp_ready = 1'b0;
        div_start = 1'b0;
        div_dvd = 62'd1 << 40;
        div_dvs = {5'b0, den};
        div_steps = W_STEPS;
        crd_req.start = 1'b0;
        crd_req.mode = CM_ROT;
        crd_x0 = GAIN_Q30;
        crd_y0 = '0;
        crd_z0 = sc_flip ? sc_z0 + 32'h8000_0000 : sc_z0;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_hyp_ready = 1'b1;
                if (i_hyp_valid) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (keep) begin
                    if (den <= SAT_DEN) begin
                        n_state = S_SC_START;
                    end else begin
                        div_start = 1'b1;
                        n_state = S_WWAIT;
                    end
                end else if (r_hyp.last_in_frame) begin
                    n_state = S_FEND;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WWAIT: begin
                if (div_done) begin
                    n_state = S_SC_START;
                end
            end
            S_SC_START: begin
                crd_req.start = 1'b1;
                n_state = S_SC_WAIT;
            end
            S_SC_WAIT: begin
                if (crd_done) begin
                    n_state = S_M0;
                end
            end
            S_M0: n_state = S_M1;
            S_M1: n_state = S_M2;
            S_M2: n_state = S_M3;
            S_M3: n_state = S_M4;
            S_M4: n_state = r_hyp.last_in_frame ? S_FEND : S_IDLE;
            S_FEND: begin
                if (r_count == '0) begin
                    n_state = S_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state = S_DX_WAIT;
                end
                div_dvd = mean_n[61] ? ~mean_n : mean_n;
                div_dvs = {r_sw, 1'b0};
                div_steps = M_STEPS;
            end
            S_DX_WAIT: begin
                if (div_done) begin
                    n_state = S_DY_START;
                end
            end
            S_DY_START: begin
                div_start = 1'b1;
                div_dvd = mean_n[61] ? ~mean_n : mean_n;
                div_dvs = {r_sw, 1'b0};
                div_steps = M_STEPS;
                n_state = S_DY_WAIT;
            end
            S_DY_WAIT: begin
                if (div_done) begin
                    n_state = S_AT_PREP;
                end
            end
            S_AT_PREP: begin
                n_state = ((r_sc == '0) && (r_ss == '0)) ? S_G0 : S_AT_NORM;
            end
            S_AT_NORM: begin
                crd_req.mode = CM_VEC;
                crd_x0 = r_ax;
                crd_y0 = r_ay;
                crd_z0 = r_az;
                if (!norm_small) begin
                    crd_req.start = 1'b1;
                    n_state = S_AT_WAIT;
                end
            end
            S_AT_WAIT: begin
                if (crd_done) begin
                    n_state = S_G0;
                end
            end
            S_G0: n_state = r_have_est ? S_G1 : S_OUT;
            S_G1: n_state = S_G2;
            S_G2: n_state = S_G3;
            S_G3: n_state = S_G4;
            S_G4: n_state = S_OUT;
            S_OUT: begin
                if (!r_out_valid || i_pose_ready) begin
                    out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rms_limit <= 24'd229376;
            r_eps <= 17'd1;
            r_gate <= 25'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RMS_LIMIT: r_rms_limit <= i_cfg_data[23:0];
                REG_WEIGHT_EPS: r_eps <= i_cfg_data[16:0];
                REG_GATE_DIST: r_gate <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0;
            r_sy <= '0;
            r_sc <= '0;
            r_ss <= '0;
            r_sw <= '0;
            r_count <= '0;
            r_est_x <= '0;
            r_est_y <= '0;
            r_est_yaw <= '0;
            r_have_est <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pose_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_M1: r_sx <= r_sx + 60'(r_prod);
                S_M2: r_sy <= r_sy + 60'(r_prod);
                S_M3: r_sc <= r_sc + 44'(r_prod);
                S_M4: begin
                    r_ss <= r_ss + 44'(r_prod);
                    r_sw <= r_sw + 29'(r_w);
                    r_count <= r_count + CNT_W'(1);
                end
                default: ;
            endcase
            if ((r_state == S_FEND && r_count == '0) || out_load) begin
                r_sx <= '0;
                r_sy <= '0;
                r_sc <= '0;
                r_ss <= '0;
                r_sw <= '0;
                r_count <= '0;
            end
            if (out_load && r_src != SRC_REJECT) begin
                r_est_x <= r_mx;
                r_est_y <= r_my;
                r_est_yaw <= r_myaw;
                r_have_est <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        if (r_state == S_IDLE && i_hyp_valid) begin
            r_hyp <= i_hyp;
        end
        if (r_state == S_CHECK) begin
            r_w <= WEIGHT_MAX;
        end
        if (r_state == S_WWAIT && div_done) begin
            r_w <= div_q[23:0];
        end
        if (r_state == S_SC_START) begin
            r_flip <= sc_flip;
        end
        if (r_state == S_SC_WAIT && crd_done) begin
            r_c <= r_flip ? -18'(c_raw) : 18'(c_raw);
            r_s <= r_flip ? -18'(s_raw) : 18'(s_raw);
        end
        if (r_state == S_FEND || r_state == S_DY_START) begin
            r_neg <= mean_n[61];
        end
        if (r_state == S_DX_WAIT && div_done) begin
            r_mx <= 32'(mean_q);
        end
        if (r_state == S_DY_WAIT && div_done) begin
            r_my <= 32'(mean_q);
        end
        if (r_state == S_AT_PREP) begin
            r_myaw <= '0;
            if (r_sc[43]) begin
                r_ax <= -CRD_W'(r_sc);
                r_ay <= -CRD_W'(r_ss);
                r_az <= 32'h8000_0000;
            end else begin
                r_ax <= CRD_W'(r_sc);
                r_ay <= CRD_W'(r_ss);
                r_az <= 32'h0000_0000;
            end
        end
        if (r_state == S_AT_NORM && norm_small) begin
            r_ax <= r_ax <<< 1;
            r_ay <= r_ay <<< 1;
        end
        if (r_state == S_AT_WAIT && crd_done) begin
            r_myaw <= $signed(16'((crd_z + 32'h0000_8000) >> 16));
        end
        if (r_state == S_G0) begin
            r_adx <= dx[32] ? 33'(-dx) : 33'(dx);
            r_ady <= dy[32] ? 33'(-dy) : 33'(dy);
            r_src <= r_have_est ? SRC_ACCEPT : SRC_FIRST;
        end
        if (r_state == S_G1) begin
            r_prerej <= (r_adx > {8'b0, r_gate}) || (r_ady > {8'b0, r_gate});
        end
        if (r_state == S_G2) begin
            r_sq <= 51'(r_prod);
        end
        if (r_state == S_G3) begin
            r_sq <= r_sq + 51'(r_prod);
        end
        if (r_state == S_G4 && (r_prerej || r_sq > 51'(r_prod))) begin
            r_src <= SRC_REJECT;
        end
        if (out_load) begin
            r_out.pose_origin <= r_src;
            if (r_src == SRC_REJECT) begin
                r_out.pose_x <= r_est_x;
                r_out.pose_y <= r_est_y;
                r_out.pose_yaw <= r_est_yaw;
            end else begin
                r_out.pose_x <= r_mx;
                r_out.pose_y <= r_my;
                r_out.pose_yaw <= r_myaw;
            end
        end
    end

    wpfg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .i_steps    (div_steps),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    wpfg_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (crd_req),
        .i_x     (crd_x0),
        .i_y     (crd_y0),
        .i_z     (crd_z0),
        .o_done  (crd_done),
        .o_x     (crd_x),
        .o_y     (crd_y),
        .o_z     (crd_z)
    );

    assign o_pose_valid = r_out_valid;
    assign o_pose = r_out;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_HYPOTHESES))
        else $error("hypothesis count beyond limit");

    a_first_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_src == SRC_FIRST) |-> !r_have_est)
        else $error("first estimate reported twice");

    a_have_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_src != SRC_REJECT) |=> r_have_est)
        else $error("stored pose not marked");

    a_no_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!div_done && !crd_done))
        else $error("unit finished while idle");
`endif

endmodule

/* dv/weighted_pose_fusion_gate_chk.sv */
`timescale 1ns / 100ps

module weighted_pose_fusion_gate_chk
    import wpfg_pkg::*;
#(
    parameter int MAX_HYPOTHESES = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_hyp_valid,
    input  logic        i_hyp_ready,
    input  t_hyp        i_hyp,
    input  logic        i_pose_valid,
    input  logic        i_pose_ready,
    input  t_pose       i_pose,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [24:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [31:0] ARCTAN [24] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
        32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
        32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
        32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
    };
    localparam longint NORM_EDGE = 64'sd1 <<< 44;

    logic [23:0] rms_limit_q;
    logic [16:0] epsilon_q;
    logic [24:0] gate_q;
    longint      wx_sum, wy_sum, wcos_sum, wsin_sum, weight_sum;
    int          kept_count;
    longint      held_x, held_y, held_yaw;
    bit          pose_held;
    t_pose       expected_poses[$];

    function automatic void yaw_to_cos_sin(input logic [15:0] ang, output longint c,
                                           output longint s);
        logic [31:0] z;
        logic [31:0] quad;
        bit          flip;
        longint      x, y, xs, ys;
        z = {ang, 16'h0000};
        quad = z + 32'h4000_0000;
        flip = quad[31];
        if (flip) begin
            z = z + 32'h8000_0000;
        end
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (!z[31]) begin
                x = x - ys; y = y + xs; z = z - ARCTAN[i];
            end else begin
                x = x + ys; y = y - xs; z = z + ARCTAN[i];
            end
        end
        x = (x + 32768) >>> 16;
        y = (y + 32768) >>> 16;
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint mean_yaw(input longint sy, input longint sx);
        logic [31:0] z;
        logic [31:0] rounded;
        longint      xs, ys;
        z = 32'h0;
        if (sx == 0 && sy == 0) begin
            return 0;
        end
        if (sx < 0) begin
            sx = -sx; sy = -sy; z = 32'h8000_0000;
        end
        while ((sx < 0 ? -sx : sx) < NORM_EDGE && (sy < 0 ? -sy : sy) < NORM_EDGE) begin
            sx = sx * 2; sy = sy * 2;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = sx >>> i;
            ys = sy >>> i;
            if (sy > 0) begin
                sx = sx + ys; sy = sy - xs; z = z + ARCTAN[i];
            end else begin
                sx = sx - ys; sy = sy + xs; z = z - ARCTAN[i];
            end
        end
        rounded = z + 32'h0000_8000;
        return longint'($signed(rounded[31:16]));
    endfunction

    function automatic longint rounded_mean(input longint num, input longint den);
        longint n, d;
        n = 2 * num + den;
        d = 2 * den;
        if (n >= 0) begin
            return n / d;
        end
        return -1 - ((-1 - n) / d);
    endfunction

    function automatic void clear_frame();
        wx_sum = 0; wy_sum = 0; wcos_sum = 0; wsin_sum = 0;
        weight_sum = 0; kept_count = 0;
    endfunction

    function automatic void fuse_hypothesis(input t_hyp h);
        longint den, w, c, s, mx, my, myaw, adx, ady, g;
        logic [1:0] src;
        t_pose p;
        if (h.hyp_rms <= rms_limit_q && kept_count < MAX_HYPOTHESES) begin
            den = longint'(h.hyp_rms) + longint'(epsilon_q);
            w = (den == 0) ? 64'd16777215 : (64'sd1 <<< 40) / den;
            if (w > 16777215) begin
                w = 16777215;
            end
            yaw_to_cos_sin(h.hyp_yaw, c, s);
            wx_sum = wx_sum + w * longint'(h.hyp_x);
            wy_sum = wy_sum + w * longint'(h.hyp_y);
            wcos_sum = wcos_sum + w * c;
            wsin_sum = wsin_sum + w * s;
            weight_sum = weight_sum + w;
            kept_count++;
        end
        if (!h.last_in_frame) begin
            return;
        end
        if (kept_count == 0 || weight_sum == 0) begin
            clear_frame();
            return;
        end
        mx = rounded_mean(wx_sum, weight_sum);
        my = rounded_mean(wy_sum, weight_sum);
        myaw = mean_yaw(wsin_sum, wcos_sum);
        clear_frame();
        if (!pose_held) begin
            held_x = mx; held_y = my; held_yaw = myaw;
            pose_held = 1;
            src = SRC_FIRST;
        end else begin
            adx = mx - held_x;
            ady = my - held_y;
            adx = adx < 0 ? -adx : adx;
            ady = ady < 0 ? -ady : ady;
            g = longint'(gate_q);
            if (adx > g || ady > g || adx * adx + ady * ady > g * g) begin
                src = SRC_REJECT;
            end else begin
                held_x = mx; held_y = my; held_yaw = myaw;
                src = SRC_ACCEPT;
            end
        end
        p.pose_x = held_x[31:0];
        p.pose_y = held_y[31:0];
        p.pose_yaw = held_yaw[15:0];
        p.pose_origin = src;
        expected_poses = {expected_poses, p};
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: pose %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_pose want;
        if (!i_rst_n) begin
            rms_limit_q = 24'd229376;
            epsilon_q = 17'd1;
            gate_q = 25'd65536;
            clear_frame();
            held_x = 0; held_y = 0; held_yaw = 0;
            pose_held = 0;
            expected_poses.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RMS_LIMIT: rms_limit_q = i_cfg_data[23:0];
                    REG_WEIGHT_EPS: epsilon_q = i_cfg_data[16:0];
                    REG_GATE_DIST: gate_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_hyp_valid && i_hyp_ready) begin
                fuse_hypothesis(i_hyp);
            end
            if (i_pose_valid && i_pose_ready) begin
                if (expected_poses.size() == 0) begin
                    $display("%0t: pose with no request waiting for one", $realtime);
                    o_fail_count++;
                end else begin
                    want = expected_poses.pop_front();
                    if (i_pose.pose_x !== want.pose_x)
                        report_mismatch("x", i_pose.pose_x, want.pose_x);
                    if (i_pose.pose_y !== want.pose_y)
                        report_mismatch("y", i_pose.pose_y, want.pose_y);
                    if (i_pose.pose_yaw !== want.pose_yaw)
                        report_mismatch("yaw", i_pose.pose_yaw, want.pose_yaw);
                    if (i_pose.pose_origin !== want.pose_origin)
                        report_mismatch("origin", i_pose.pose_origin, want.pose_origin);
                end
            end
        end
        o_pending = expected_poses.size();
    end

endmodule

/* dv/weighted_pose_fusion_gate_tb.sv */
`timescale 1ns / 100ps

module weighted_pose_fusion_gate_tb;
    import wpfg_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        hyp_valid = 1'b0;
    logic        hyp_ready;
    t_hyp        hyp = '0;
    logic        pose_valid;
    logic        pose_ready = 1'b0;
    t_pose       pose;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = REG_RMS_LIMIT;
    logic [24:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          sender_idle = 0;
    int          receiver_stall = 0;
    logic        hold_ready = 1'b0;
    int          sent = 0;
    longint      centre_x = 0;
    longint      centre_y = 0;
    int          centre_yaw = 0;

    weighted_pose_fusion_gate dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_hyp_valid(hyp_valid), .o_hyp_ready(hyp_ready), .i_hyp(hyp),
        .o_pose_valid(pose_valid), .i_pose_ready(pose_ready), .o_pose(pose),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    weighted_pose_fusion_gate_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_hyp_valid(hyp_valid), .i_hyp_ready(hyp_ready), .i_hyp(hyp),
        .i_pose_valid(pose_valid), .i_pose_ready(pose_ready), .i_pose(pose),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge i_clk) begin
        pose_ready <= !hold_ready && ($urandom_range(99) >= receiver_stall);
    end

    task automatic send_hyp(input t_hyp h);
        while ($urandom_range(99) < sender_idle) begin
            hyp_valid <= 1'b0;
            @(posedge i_clk);
        end
        hyp_valid <= 1'b1;
        hyp <= h;
        do @(posedge i_clk); while (!hyp_ready);
        sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [24:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // The block may still be busy with a request that closes an empty frame.
    task automatic settle();
        hyp_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic t_hyp near_hyp(input bit last, input int spread);
        t_hyp h;
        int   pick;
        h.hyp_x = 32'(centre_x + $urandom_range(2 * spread) - spread);
        h.hyp_y = 32'(centre_y + $urandom_range(2 * spread) - spread);
        h.hyp_yaw = 16'(centre_yaw + $urandom_range(8000) - 4000);
        pick = $urandom_range(9);
        h.hyp_rms = pick == 0 ? 24'd0 : pick == 1 ? 24'($urandom) :
                    24'($urandom_range(1, 300000));
        h.last_in_frame = last;
        return h;
    endfunction

    task automatic send_frame(input int count, input bit noise);
        t_hyp h;
        for (int k = 0; k < count; k++) begin
            if (noise) begin
                h.hyp_x = $urandom;
                h.hyp_y = $urandom;
                h.hyp_yaw = 16'($urandom);
                h.hyp_rms = 24'($urandom >> $urandom_range(8, 31));
                h.last_in_frame = $urandom_range(3) == 0;
            end else begin
                h = near_hyp(k == count - 1, 30000);
            end
            send_hyp(h);
        end
    endtask

    task automatic run_phase(input int items);
        int target;
        target = sent + items;
        while (sent < target) begin
            case ($urandom_range(9))
                0: begin
                    centre_x = longint'($signed($urandom)) >>> $urandom_range(1, 8);
                    centre_y = longint'($signed($urandom)) >>> $urandom_range(1, 8);
                end
                1: centre_yaw = $urandom_range(65535) - 32768;
                default: begin
                    centre_x = centre_x + $urandom_range(40000) - 20000;
                    centre_y = centre_y + $urandom_range(40000) - 20000;
                end
            endcase
            send_frame($urandom_range(1, 20), $urandom_range(9) == 0);
        end
    endtask

    initial begin
        t_hyp h;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        h = '{hyp_x: 32'sh7FFF_FFFF, hyp_y: 32'sh8000_0000, hyp_yaw: 16'sh8000,
              hyp_rms: 24'd0, last_in_frame: 1'b1};
        send_hyp(h);
        h = '{hyp_x: 32'sh7FFF_FFF0, hyp_y: 32'sh8000_0010, hyp_yaw: 16'sh7FFF,
              hyp_rms: 24'd229376, last_in_frame: 1'b1};
        send_hyp(h);
        h = '{hyp_x: 32'sh8000_0000, hyp_y: 32'sh7FFF_FFFF, hyp_yaw: 16'sh4000,
              hyp_rms: 24'd229377, last_in_frame: 1'b1};
        send_hyp(h);
        h = '{hyp_x: 32'sh7FFF_FFFF, hyp_y: 32'sh8000_0000, hyp_yaw: 16'sh0000,
              hyp_rms: 24'd100, last_in_frame: 1'b0};
        send_hyp(h);
        h.hyp_yaw = 16'sh8000;
        h.last_in_frame = 1'b1;
        send_hyp(h);
        for (int k = 0; k < 18; k++) begin
            h = '{hyp_x: 32'sh7FFF_FFFF, hyp_y: 32'sh8000_0000, hyp_yaw: 16'(k * 3641),
                  hyp_rms: 24'(k), last_in_frame: k == 17};
            send_hyp(h);
        end
        settle();

        // Zero denominator and a zero gate at an unchanged position.
        write_reg(REG_WEIGHT_EPS, 25'd0);
        write_reg(REG_GATE_DIST, 25'd0);
        write_reg(REG_RMS_LIMIT, 25'hFF_FFFF);
        h = '{hyp_x: 32'sh7FFF_FFFF, hyp_y: 32'sh8000_0000, hyp_yaw: 16'sh3FFF,
              hyp_rms: 24'd0, last_in_frame: 1'b1};
        send_hyp(h);
        send_hyp(h);
        h.hyp_rms = 24'hFF_FFFF;
        send_hyp(h);
        settle();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                1: begin
                    write_reg(REG_RMS_LIMIT, 25'hFF_FFFF);
                    write_reg(REG_WEIGHT_EPS, 25'd1);
                    write_reg(REG_GATE_DIST, 25'd16777216);
                end
                2: begin
                    write_reg(REG_RMS_LIMIT, 25'd0);
                    write_reg(REG_WEIGHT_EPS, 25'd65536);
                    write_reg(REG_GATE_DIST, 25'd0);
                end
                3: begin
                    write_reg(REG_RMS_LIMIT, 25'd229376);
                    write_reg(REG_WEIGHT_EPS, 25'd65536);
                    write_reg(REG_GATE_DIST, 25'd65536);
                end
                4, 5: begin
                    write_reg(REG_RMS_LIMIT, 25'($urandom_range(1000, 16777215)));
                    write_reg(REG_WEIGHT_EPS, 25'($urandom_range(1, 65536)));
                    write_reg(REG_GATE_DIST, 25'($urandom_range(0, 16777216)));
                end
                default: ;
            endcase
            sender_idle = (phase % 4 == 1 || phase % 4 == 3) ? 70 : 0;
            receiver_stall = (phase % 4 == 2) ? 70 : (phase % 4 == 3) ? 14 : 0;
            if (phase % 4 == 3) begin
                sender_idle = 14;
            end
            if (phase == 1) begin
                fork
                    begin
                        hold_ready <= 1'b1;
                        repeat (6000) @(posedge i_clk);
                        hold_ready <= 1'b0;
                    end
                join_none
            end
            run_phase(phase == 2 ? 150 : 330);
            settle();
        end

        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
